/* rtl/core/range_max_segment_tree_core_assert.svh */
// Assertion macros shared by the checker of the range-maximum tree core.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef RANGE_MAX_SEGMENT_TREE_CORE_ASSERT_SVH
`define RANGE_MAX_SEGMENT_TREE_CORE_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent, outside reset.
`define RMST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent, outside reset.
`define RMST_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after reset is seen.
`define RMST_ASSERT_RESET(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

/* rtl/core/rmst_pkg.sv */
// Shared types, constants and helpers for the range-maximum segment tree core.
// No dependencies; every module in this folder imports it.
package rmst_pkg;

  localparam int LEAVES     = 1024;
  localparam int NODE_COUNT = 2 * LEAVES;
  localparam int POS_W      = $clog2(LEAVES);
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int LEN_W      = POS_W + 1;
  localparam int DATA_W     = 32;

  localparam logic signed [DATA_W-1:0] SENTINEL = -32'sd2000000000;

  typedef enum logic {
    CMD_UPDATE = 1'b0,
    CMD_QUERY  = 1'b1
  } cmd_t;

  // Input item as carried on the input channel.
  typedef struct packed {
    cmd_t                      cmd;
    logic [POS_W-1:0]          position;
    logic signed [DATA_W-1:0]  new_value;
    logic [POS_W-1:0]          query_low;
    logic [POS_W-1:0]          query_high;
  } in_item_t;

  // Result item as carried on the output channel.
  typedef struct packed {
    logic signed [DATA_W-1:0]  max_value;
    logic                      range_empty;
  } out_item_t;

  // One access of the node store: one write port and one read port.
  typedef struct packed {
    logic                      we;
    logic [NODE_W-1:0]         waddr;
    logic signed [DATA_W-1:0]  wdata;
    logic                      re;
    logic [NODE_W-1:0]         raddr;
  } ram_req_t;

  // Status of the tree walker seen by the top level.
  typedef struct packed {
    logic idle;
    logic done;
  } walk_stat_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD_DOWN,
    ST_UPD_READ,
    ST_UPD_WRITE,
    ST_Q_SPLIT,
    ST_Q_LEFT,
    ST_Q_RIGHT,
    ST_DRAIN,
    ST_DONE
  } walk_state_t;

  function automatic logic signed [DATA_W-1:0] smax(
    input logic signed [DATA_W-1:0] a,
    input logic signed [DATA_W-1:0] b
  );
    return (a > b) ? a : b;
  endfunction

endpackage

/* rtl/core/range_max_segment_tree_core.sv */
// Range-maximum segment tree over 1024 signed 32-bit leaves, one item at a time.
// Updates write the leaf, then each parent in turn; each parent write waits on its sibling
// read. An empty query ends without touching the store; an update past the end reads the root.
// The next item is taken only after the previous result has been registered.
// Reset: synchronous; a clearing pass writes the sentinel to every node, with the input
// stalled; active_length resets to 1024.
module range_max_segment_tree_core
  import rmst_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_item,
  input  logic             active_length_we,
  input  logic [LEN_W-1:0] active_length_data
);

  logic [LEN_W-1:0]         active_length;
  logic [POS_W-1:0]         n_m1;
  logic                     start, take;
  walk_stat_t               stat;
  out_item_t                result;
  ram_req_t                 req;
  logic signed [DATA_W-1:0] rdata;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_length <= LEN_W'(LEAVES);
    end else if (active_length_we) begin
      active_length <= active_length_data;
    end
  end

  // Last leaf index, with the length held to 1 .. LEAVES.
  always_comb begin
    if (active_length == '0) begin
      n_m1 = '0;
    end else if (active_length > LEN_W'(LEAVES)) begin
      n_m1 = POS_W'(LEAVES - 1);
    end else begin
      n_m1 = POS_W'(active_length - LEN_W'(1));
    end
  end

  // Handshakes: take a new item when the walker is idle, hand results to the
  // output register whenever it is empty or being emptied.
  assign in_stall = !stat.idle;
  assign start    = in_valid && !in_stall;
  assign take     = stat.done && (!out_valid || !out_stall);

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_item <= result;
    end
  end

  rmst_walker u_walker (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (in_item),
    .n_m1   (n_m1),
    .take   (take),
    .stat   (stat),
    .result (result),
    .req    (req),
    .rdata  (rdata)
  );

  rmst_node_ram u_ram (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

endmodule

/* rtl/core/rmst_node_ram.sv */
// Node store of the segment tree: one write port and one registered read port.
// Depends on rmst_pkg for the request type and widths.
module rmst_node_ram
  import rmst_pkg::*;
(
  input  logic                     clk,
  input  ram_req_t                 req,
  output logic signed [DATA_W-1:0] rdata
);

  logic signed [DATA_W-1:0] mem [NODE_COUNT];

  // Write and registered read of the node array.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

/* rtl/core/rmst_walker.sv */
// Sequencer that walks the tree node by node for updates and queries,
// sharing one midpoint/compare step and one max unit. Also clears the store.
// Depends on rmst_pkg and drives the node store in rmst_node_ram.
module rmst_walker
  import rmst_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  in_item_t                 item,
  input  logic [POS_W-1:0]         n_m1,
  input  logic                     take,
  output walk_stat_t               stat,
  output out_item_t                result,
  output ram_req_t                 req,
  input  logic signed [DATA_W-1:0] rdata
);

  walk_state_t              state, state_next;
  logic [POS_W-1:0]         l, l_next, r, r_next;
  logic [POS_W-1:0]         rl, rl_next, rr, rr_next;
  logic [NODE_W-1:0]        k, k_next, rk, rk_next;
  logic [POS_W-1:0]         ql, ql_next, qr, qr_next, pos, pos_next;
  logic signed [DATA_W-1:0] val, val_next, best, best_next;
  logic                     empty, empty_next;
  logic                     pend, pend_next, load, load_next;
  logic [NODE_W-1:0]        clr_cnt, clr_cnt_next;

  logic [POS_W-1:0]         mid;
  logic [NODE_W-1:0]        k_left, k_right, k_up;
  logic signed [DATA_W-1:0] up_value;

  // Shared step unit: midpoint of the current interval and child indexes.
  assign mid      = l + ((r - l) >> 1);
  assign k_left   = {k[NODE_W-2:0], 1'b0};
  assign k_right  = {k[NODE_W-2:0], 1'b1};
  assign k_up     = k >> 1;
  assign up_value = smax(best, rdata);

  assign stat.idle          = (state == ST_IDLE);
  assign stat.done          = (state == ST_DONE);
  assign result.max_value   = best;
  assign result.range_empty = empty;

  // Control state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      pend    <= 1'b0;
    end else begin
      state   <= state_next;
      clr_cnt <= clr_cnt_next;
      pend    <= pend_next;
    end
  end

  // Walk registers and the running result.
  always_ff @(posedge clk) begin
    l     <= l_next;
    r     <= r_next;
    k     <= k_next;
    rl    <= rl_next;
    rr    <= rr_next;
    rk    <= rk_next;
    ql    <= ql_next;
    qr    <= qr_next;
    pos   <= pos_next;
    val   <= val_next;
    best  <= best_next;
    empty <= empty_next;
    load  <= load_next;
  end

  // Next state, store accesses and result accumulation.
  always_comb begin
    state_next   = state;
    l_next       = l;
    r_next       = r;
    k_next       = k;
    rl_next      = rl;
    rr_next      = rr;
    rk_next      = rk;
    ql_next      = ql;
    qr_next      = qr;
    pos_next     = pos;
    val_next     = val;
    empty_next   = empty;
    load_next    = load;
    clr_cnt_next = clr_cnt;
    pend_next    = 1'b0;
    req          = '0;

    // Fold in the node read issued in the previous cycle.
    best_next = best;
    if (pend) begin
      best_next = load ? rdata : smax(best, rdata);
    end

    unique case (state)
      ST_CLEAR: begin
        req.we       = 1'b1;
        req.waddr    = clr_cnt;
        req.wdata    = SENTINEL;
        clr_cnt_next = clr_cnt + NODE_W'(1);
        if (clr_cnt == NODE_W'(NODE_COUNT - 1)) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start) begin
          pos_next   = item.position;
          val_next   = item.new_value;
          ql_next    = item.query_low;
          qr_next    = (item.query_high > n_m1) ? n_m1 : item.query_high;
          l_next     = '0;
          r_next     = n_m1;
          k_next     = NODE_W'(1);
          empty_next = 1'b0;
          best_next  = SENTINEL;
          if (item.cmd == CMD_UPDATE) begin
            if (item.position <= n_m1) begin
              state_next = ST_UPD_DOWN;
            end else begin
              // Position past the end: report the root as it stands.
              req.re     = 1'b1;
              req.raddr  = NODE_W'(1);
              pend_next  = 1'b1;
              load_next  = 1'b1;
              state_next = ST_DRAIN;
            end
          end else if (item.query_low > item.query_high || item.query_low > n_m1) begin
            empty_next = 1'b1;
            state_next = ST_DONE;
          end else begin
            state_next = ST_Q_SPLIT;
          end
        end
      end

      ST_UPD_DOWN: begin
        if (l == r) begin
          req.we    = 1'b1;
          req.waddr = k;
          req.wdata = val;
          best_next = val;
          state_next = (k == NODE_W'(1)) ? ST_DONE : ST_UPD_READ;
        end else if (pos <= mid) begin
          r_next = mid;
          k_next = k_left;
        end else begin
          l_next = mid + POS_W'(1);
          k_next = k_right;
        end
      end

      ST_UPD_READ: begin
        // Sibling of the node just written; best holds that node's value.
        req.re     = 1'b1;
        req.raddr  = k ^ NODE_W'(1);
        state_next = ST_UPD_WRITE;
      end

      ST_UPD_WRITE: begin
        req.we     = 1'b1;
        req.waddr  = k_up;
        req.wdata  = up_value;
        best_next  = up_value;
        k_next     = k_up;
        state_next = (k_up == NODE_W'(1)) ? ST_DONE : ST_UPD_READ;
      end

      ST_Q_SPLIT: begin
        // Descend until the range either is covered or splits in two.
        if (ql <= l && qr >= r) begin
          req.re     = 1'b1;
          req.raddr  = k;
          pend_next  = 1'b1;
          load_next  = (k == NODE_W'(1));
          state_next = ST_DRAIN;
        end else if (qr <= mid) begin
          r_next = mid;
          k_next = k_left;
        end else if (ql > mid) begin
          l_next = mid + POS_W'(1);
          k_next = k_right;
        end else begin
          rl_next    = mid + POS_W'(1);
          rr_next    = r;
          rk_next    = k_right;
          r_next     = mid;
          k_next     = k_left;
          state_next = ST_Q_LEFT;
        end
      end

      ST_Q_LEFT: begin
        // Left boundary path: the right edge is always covered here.
        load_next = 1'b0;
        if (ql <= l) begin
          req.re     = 1'b1;
          req.raddr  = k;
          pend_next  = 1'b1;
          l_next     = rl;
          r_next     = rr;
          k_next     = rk;
          state_next = ST_Q_RIGHT;
        end else if (ql <= mid) begin
          req.re    = 1'b1;
          req.raddr = k_right;
          pend_next = 1'b1;
          r_next    = mid;
          k_next    = k_left;
        end else begin
          l_next = mid + POS_W'(1);
          k_next = k_right;
        end
      end

      ST_Q_RIGHT: begin
        // Right boundary path: the left edge is always covered here.
        load_next = 1'b0;
        if (qr >= r) begin
          req.re     = 1'b1;
          req.raddr  = k;
          pend_next  = 1'b1;
          state_next = ST_DRAIN;
        end else if (qr > mid) begin
          req.re    = 1'b1;
          req.raddr = k_left;
          pend_next = 1'b1;
          l_next    = mid + POS_W'(1);
          k_next    = k_right;
        end else begin
          r_next = mid;
          k_next = k_left;
        end
      end

      ST_DRAIN: begin
        state_next = ST_DONE;
      end

      ST_DONE: begin
        if (take) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/rmst_checker.sv */
// Port-level checker for the range-maximum tree core, bound to the top level.
// Depends on rmst_pkg and range_max_segment_tree_core_assert.svh.
`include "range_max_segment_tree_core_assert.svh"

module rmst_checker
  import rmst_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  // The core holds off new items during the clearing pass after reset.
  `RMST_ASSERT_RESET(a_stall_after_reset, in_stall && !out_valid, "input open after reset")

  // One item at a time: an accepted item keeps the input stalled next cycle.
  `RMST_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "second item taken while busy")

  // An empty range always reports the sentinel.
  `RMST_ASSERT_SAME(a_empty_is_sentinel, out_valid && out_item.range_empty, out_item.max_value == SENTINEL, "empty range without sentinel")

  // A stalled result stays in place.
  `RMST_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item), "stalled result changed")

endmodule

bind range_max_segment_tree_core rmst_checker u_rmst_checker (.*);

/* tb/range_max_segment_tree_core_tb.sv */
// Self-checking testbench for the range-maximum segment tree core.
// Depends on rmst_pkg for the item types, widths and the sentinel value.
// Directed rows and random items are checked against a behavioral tree model or fixed results.
module range_max_segment_tree_core_tb;
  import rmst_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [DATA_W-1:0] TOP_VAL    = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] BOTTOM_VAL = 32'sh8000_0000;
  localparam int PHASES     = 10;
  localparam int PHASE_ITEMS = 85;
  localparam int HOLD_CYCLES = 300;

  // One row of the directed plan: either a length write or an item.
  typedef struct {
    bit               is_cfg;
    logic [LEN_W-1:0] len;
    in_item_t         item;
    bit               known;
    out_item_t        want;
  } plan_row_t;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  in_item_t         in_item;
  logic             out_valid;
  logic             out_stall;
  out_item_t        out_item;
  logic             active_length_we;
  logic [LEN_W-1:0] active_length_data;

  // Behavioral copy of the node store and the length register.
  logic signed [DATA_W-1:0] tree_node [0:NODE_COUNT-1];
  logic [LEN_W-1:0]         len_setting;

  out_item_t pending_results [$];
  plan_row_t plan [$];

  int  mismatches = 0;
  int  results_seen = 0;
  int  n_updates = 0;
  int  n_queries = 0;
  int  n_empty = 0;
  int  n_settings = 0;
  bit  hold_done = 1'b0;
  bit  in_no_gaps = 1'b0;

  range_max_segment_tree_core DUT (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_item            (in_item),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_item           (out_item),
    .active_length_we   (active_length_we),
    .active_length_data (active_length_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Tree model
  // ---------------------------------------------------------------------------

  function automatic logic signed [DATA_W-1:0] larger(
    input logic signed [DATA_W-1:0] a,
    input logic signed [DATA_W-1:0] b
  );
    return (a > b) ? a : b;
  endfunction

  // Nodes past the end of the store read as empty and ignore writes.
  function automatic logic signed [DATA_W-1:0] node_rd(input int unsigned k);
    if (k >= NODE_COUNT) return SENTINEL;
    return tree_node[k];
  endfunction

  function automatic void node_wr(input int unsigned k, input logic signed [DATA_W-1:0] v);
    if (k < NODE_COUNT) tree_node[k] = v;
  endfunction

  // A zero length acts as one leaf; anything above the store size is clipped.
  function automatic int unsigned span_of(input logic [LEN_W-1:0] v);
    if (v == 0) return 1;
    if (v > LEAVES) return LEAVES;
    return v;
  endfunction

  // Write one leaf, then rebuild the maxima on the way back to the root.
  function automatic void tree_put(
    input int unsigned pos,
    input logic signed [DATA_W-1:0] v,
    input int unsigned n
  );
    int unsigned trail [16];
    int          depth;
    int          i;
    int unsigned k, l, r, mid;
    k = 1;
    l = 0;
    r = n - 1;
    depth = 0;
    while (l != r) begin
      trail[depth] = k;
      depth++;
      mid = l + (r - l) / 2;
      if (pos <= mid) begin
        k = 2 * k;
        r = mid;
      end else begin
        k = 2 * k + 1;
        l = mid + 1;
      end
    end
    node_wr(k, v);
    for (i = depth - 1; i >= 0; i--) begin
      node_wr(trail[i], larger(node_rd(2 * trail[i]), node_rd(2 * trail[i] + 1)));
    end
  endfunction

  // A root that is covered whole returns its raw value; any other walk starts
  // from the sentinel, so its result never drops below it.
  function automatic logic signed [DATA_W-1:0] range_max(
    input int unsigned ql,
    input int unsigned qr,
    input int unsigned n
  );
    int unsigned sk [64];
    int unsigned sl [64];
    int unsigned sr [64];
    int          sp;
    int unsigned k, l, r, mid;
    logic signed [DATA_W-1:0] best;
    if (ql == 0 && qr >= n - 1) return node_rd(1);
    best = SENTINEL;
    sk[0] = 1;
    sl[0] = 0;
    sr[0] = n - 1;
    sp = 1;
    while (sp > 0) begin
      sp--;
      k = sk[sp];
      l = sl[sp];
      r = sr[sp];
      if (ql <= l && qr >= r) begin
        best = larger(best, node_rd(k));
      end else begin
        mid = l + (r - l) / 2;
        if (ql <= mid) begin
          sk[sp] = 2 * k;
          sl[sp] = l;
          sr[sp] = mid;
          sp++;
        end
        if (qr > mid) begin
          sk[sp] = 2 * k + 1;
          sl[sp] = mid + 1;
          sr[sp] = r;
          sp++;
        end
      end
    end
    return best;
  endfunction

  // Apply one item to the model and return the result it produces.
  function automatic out_item_t tree_apply(input in_item_t it);
    int unsigned n, lo, hi;
    out_item_t   res;
    n = span_of(len_setting);
    res.range_empty = 1'b0;
    if (it.cmd == CMD_UPDATE) begin
      if (it.position < n) tree_put(it.position, it.new_value, n);
      res.max_value = node_rd(1);
    end else begin
      lo = it.query_low;
      hi = it.query_high;
      if (lo > hi || lo >= n) begin
        res.max_value = SENTINEL;
        res.range_empty = 1'b1;
      end else begin
        if (hi > n - 1) hi = n - 1;
        res.max_value = range_max(lo, hi, n);
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Item construction; fields that the operation ignores carry random bits.
  // ---------------------------------------------------------------------------

  function automatic in_item_t make_update(
    input int unsigned pos,
    input logic signed [DATA_W-1:0] v
  );
    in_item_t it;
    it.query_low  = POS_W'($urandom);
    it.query_high = POS_W'($urandom);
    it.cmd        = CMD_UPDATE;
    it.position   = POS_W'(pos);
    it.new_value  = v;
    return it;
  endfunction

  function automatic in_item_t make_query(input int unsigned lo, input int unsigned hi);
    in_item_t it;
    it.position   = POS_W'($urandom);
    it.new_value  = $urandom;
    it.cmd        = CMD_QUERY;
    it.query_low  = POS_W'(lo);
    it.query_high = POS_W'(hi);
    return it;
  endfunction

  // Values lean toward the extremes and the sentinel neighborhood.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return TOP_VAL;
      1:       return BOTTOM_VAL;
      2:       return SENTINEL;
      3:       return SENTINEL + $signed($urandom_range(0, 2)) - 1;
      4:       return $signed($urandom_range(0, 100)) - 50;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t random_item(input int unsigned n);
    int unsigned lo, hi, r;
    r = $urandom_range(0, 9);
    if ($urandom_range(0, 1) == 0) begin
      // Mostly in-range updates, now and then one past the end.
      if (r == 0) return make_update($urandom_range(0, LEAVES - 1), pick_value());
      return make_update($urandom_range(0, n - 1), pick_value());
    end
    if (r < 7) begin
      lo = $urandom_range(0, n - 1);
      hi = $urandom_range(lo, n - 1);
    end else if (r == 7) begin
      // Well-formed start, but the end may run past the active length.
      lo = $urandom_range(0, n - 1);
      hi = $urandom_range(lo, LEAVES - 1);
    end else begin
      lo = $urandom_range(0, LEAVES - 1);
      hi = $urandom_range(0, LEAVES - 1);
    end
    return make_query(lo, hi);
  endfunction

  function automatic plan_row_t row_item(input in_item_t it);
    plan_row_t row;
    row.is_cfg = 1'b0;
    row.len    = '0;
    row.item   = it;
    row.known  = 1'b0;
    row.want   = '0;
    return row;
  endfunction

  function automatic plan_row_t row_known(
    input in_item_t it,
    input logic signed [DATA_W-1:0] mx,
    input logic emp
  );
    plan_row_t row;
    row = row_item(it);
    row.known = 1'b1;
    row.want.max_value = mx;
    row.want.range_empty = emp;
    return row;
  endfunction

  function automatic plan_row_t row_len(input logic [LEN_W-1:0] len);
    plan_row_t row;
    row = row_item('0);
    row.is_cfg = 1'b1;
    row.len = len;
    return row;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Gaps are mostly short, with an occasional long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Present one item at a falling edge after an optional random gap and hold it until accepted.
  task automatic offer(input in_item_t it);
    int gap;
    gap = in_no_gaps ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  // Send an item and queue the result it should produce.
  task automatic issue(input in_item_t it, input bit known, input out_item_t want);
    out_item_t got;
    offer(it);
    got = tree_apply(it);
    if (known) got = want;
    pending_results.push_back(got);
    if (it.cmd == CMD_UPDATE) n_updates++;
    else n_queries++;
    if (got.range_empty) n_empty++;
  endtask

  // Length writes happen only once every outstanding result has come back.
  task automatic set_length(input logic [LEN_W-1:0] v);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    active_length_we   <= 1'b1;
    active_length_data <= v;
    @(negedge clk);
    active_length_we <= 1'b0;
    len_setting = v;
    n_settings++;
  endtask

  function automatic logic [LEN_W-1:0] phase_length(input int ph);
    int v;
    case (ph)
      0:       v = LEAVES;
      1:       v = 1;
      2:       v = 2;
      3:       v = $urandom_range(3, 17);
      4:       v = $urandom_range(18, 64);
      5:       v = $urandom_range(65, LEAVES - 1);
      6:       v = 0;
      7:       v = (1 << LEN_W) - 1;
      8:       v = $urandom_range(0, (1 << LEN_W) - 1);
      default: v = LEAVES;
    endcase
    return LEN_W'(v);
  endfunction

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with no item outstanding", out_item.max_value, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_item.max_value !== want.max_value)
          report_mismatch("max_value", out_item.max_value, want.max_value);
        if (out_item.range_empty !== want.range_empty)
          report_mismatch("range_empty", out_item.range_empty, want.range_empty);
      end
    end
  end

  // Receiver stalls: runs of random length, one long hold-off to back the
  // block up while items keep being offered.
  initial begin
    int len;
    int r;
    out_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!hold_done && results_seen >= 120) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          out_stall <= 1'b0;
          len = $urandom_range(1, 20);
        end else if (r < 50) begin
          out_stall <= 1'b0;
          len = 200;
        end else if (r < 90) begin
          out_stall <= 1'b1;
          len = $urandom_range(1, 3);
        end else begin
          out_stall <= 1'b1;
          len = $urandom_range(10, 40);
        end
        repeat (len) @(negedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int          i;
    int          ph;
    int          p;
    int          left;
    int unsigned n;
    rst                = 1'b1;
    in_valid           = 1'b0;
    in_item            = '0;
    active_length_we   = 1'b0;
    active_length_data = '0;
    for (i = 0; i < NODE_COUNT; i++) tree_node[i] = SENTINEL;
    len_setting = LEN_W'(LEAVES);

    // Directed rows: fresh tree, the value extremes, empty and reversed ranges,
    // updates past the end, clipped queries and out-of-range lengths.
    plan.push_back(row_known(make_query(0, LEAVES - 1), SENTINEL, 1'b0));
    plan.push_back(row_known(make_query(5, 3), SENTINEL, 1'b1));
    plan.push_back(row_known(make_update(0, TOP_VAL), TOP_VAL, 1'b0));
    plan.push_back(row_known(make_update(LEAVES - 1, BOTTOM_VAL), TOP_VAL, 1'b0));
    plan.push_back(row_known(make_query(0, 0), TOP_VAL, 1'b0));
    plan.push_back(row_item(make_query(LEAVES - 1, LEAVES - 1)));
    plan.push_back(row_known(make_update(0, BOTTOM_VAL), SENTINEL, 1'b0));
    plan.push_back(row_known(make_update(512, 0), 0, 1'b0));
    plan.push_back(row_known(make_query(0, LEAVES - 1), 0, 1'b0));
    plan.push_back(row_item(make_query(511, 513)));
    plan.push_back(row_known(make_query(LEAVES - 1, 0), SENTINEL, 1'b1));
    plan.push_back(row_known(make_query(700, 700), SENTINEL, 1'b0));
    plan.push_back(row_item(make_update(777, SENTINEL - 1)));
    plan.push_back(row_item(make_update(LEAVES - 1, 32'sh5555_5555)));
    plan.push_back(row_item(make_query(1, LEAVES - 2)));
    plan.push_back(row_len(LEN_W'(7)));
    plan.push_back(row_item(make_update(6, 100)));
    plan.push_back(row_item(make_update(7, 5)));
    plan.push_back(row_item(make_query(3, LEAVES - 1)));
    plan.push_back(row_known(make_query(7, 9), SENTINEL, 1'b1));
    plan.push_back(row_len(LEN_W'(0)));
    plan.push_back(row_item(make_query(0, 0)));
    plan.push_back(row_item(make_update(1, 9)));
    plan.push_back(row_known(make_query(1, 1), SENTINEL, 1'b1));
    plan.push_back(row_len(LEN_W'((1 << LEN_W) - 1)));
    plan.push_back(row_item(make_query(0, LEAVES - 1)));
    plan.push_back(row_item(make_update(LEAVES - 1, -1)));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[j]) begin
      if (plan[j].is_cfg) set_length(plan[j].len);
      else issue(plan[j].item, plan[j].known, plan[j].want);
    end

    // Random phases, each at its own active length. Short trees are loaded
    // in order first so that queries see populated leaves.
    for (ph = 0; ph < PHASES; ph++) begin
      set_length(phase_length(ph));
      n = span_of(len_setting);
      in_no_gaps = ($urandom_range(0, 3) == 0);
      left = PHASE_ITEMS;
      if (n <= 64) begin
        for (p = 0; p < n; p++) issue(make_update(p, pick_value()), 1'b0, '0);
        left = left - n;
      end
      for (p = 0; p < left; p++) issue(random_item(n), 1'b0, '0);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    // Give a stray extra result time to show up.
    repeat (60) @(negedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never delivered", 0, pending_results.size());

    $display("Run covered %0d updates and %0d queries (%0d empty ranges)",
             n_updates, n_queries, n_empty);
    $display("over %0d active-length writes; %0d mismatches seen", n_settings, mismatches);
    if (mismatches == 0) begin
      $display("[range_max_segment_tree_core] OK");
    end else begin
      $display("[range_max_segment_tree_core] ERROR");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run, clearing pass included.
  initial begin
    #6ms;
    $display("Run stopped by the watchdog with %0d results outstanding",
             pending_results.size());
    $display("[range_max_segment_tree_core] ERROR");
    $finish;
  end

endmodule

/* range_max_segment_tree_core.f */
+incdir+rtl/core
rtl/core/rmst_pkg.sv
rtl/core/rmst_node_ram.sv
rtl/core/rmst_walker.sv
rtl/core/range_max_segment_tree_core.sv
rtl/core/rmst_checker.sv
tb/range_max_segment_tree_core_tb.sv
